@@ sv/lsmm_pkg.sv @@
// Package of the line-suffix multi-pattern matcher: request codes, line-end
// byte codes and the structs that travel between the top level and the slot rows.
// No dependencies.
`default_nettype none

package lsmm_pkg;

  // Request codes of an input beat.
  localparam logic [1:0] REQ_STREAM = 2'd0;
  localparam logic [1:0] REQ_PAT    = 2'd1;
  localparam logic [1:0] REQ_LEN    = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  // Bytes that end a line.
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;

  // Broadcast to every match cell: advance on a byte, or drop all partial matches.
  typedef struct packed {
    logic       adv;
    logic       clr;
    logic [7:0] data;
  } lsmm_step_t;

  // An accepted load beat, broadcast to every slot row.
  typedef struct packed {
    logic       en;
    logic [1:0] req;
    logic [7:0] value;
    logic [4:0] byte_pos;
  } lsmm_load_t;

  // Which slot rows a load beat addresses.
  typedef struct packed {
    logic set_hit;
    logic slot_hit;
  } lsmm_sel_t;

endpackage

`default_nettype wire

@@ sv/line_suffix_multi_pattern_matcher_unit.sv @@
// A result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle, loads and stream bytes alike, while the output is taken
// and no rebuild runs. After pattern bytes are written, the next stream byte waits while
// the window chain rotates once to rebuild the match flags of every slot row.
// Reset: rst_ni clears the match flags, lengths, valid flags, line count and handshake
// state at once; pattern bytes stay undefined until written.
`default_nettype none

module line_suffix_multi_pattern_matcher_unit import lsmm_pkg::*; #(
  parameter int PAT_LEN  = 32,
  parameter int NUM_ALTS = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] in_req_type_i,
  input  wire logic [7:0] in_value_i,
  input  wire logic       in_pattern_set_i,
  input  wire logic [1:0] in_alt_index_i,
  input  wire logic [4:0] in_byte_pos_i,
  input  wire logic       in_check_halt_i,
  input  wire logic       in_check_wait_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            out_halt_hit_o,
  output logic            out_wait_hit_o,
  output logic            out_line_ended_o
);

  // Each slot row keeps, per prefix length, a flag that the line so far ends with
  // that prefix of its pattern. A stream byte advances every flag by one cell along
  // the row, so a slot hits when the flag at its length is set. The window chain is
  // kept only to rebuild those flags after pattern bytes change.

  localparam int SLOTS = 2 * NUM_ALTS;
  localparam int CW    = $clog2(PAT_LEN + 1);
  localparam int RW    = $clog2(PAT_LEN);

  logic             in_acc;
  logic             stream_acc;
  logic             is_end;
  logic             out_block;
  logic             start;
  logic             feed;
  logic             win_shift;
  logic [7:0]       win_in;
  logic [7:0]       win [PAT_LEN];

  logic             busy_q, busy_d;
  logic             dirty_q, dirty_d;
  logic [RW-1:0]    rcnt_q, rcnt_d;
  logic [CW-1:0]    count_q, count_d;

  logic             out_valid_q, out_valid_d;
  logic             halt_q, halt_d;
  logic             wait_q, wait_d;
  logic             ended_q, ended_d;

  lsmm_step_t       step;
  lsmm_load_t       load;
  logic [SLOTS-1:0] hit;
  logic [SLOTS-1:0] valid;
  logic             halt_any;
  logic             wait_any;
  logic             wait_empty;

  // A result beat that is stalled holds the input side back.
  assign out_block  = out_valid_q && out_stall_i;
  assign is_end     = (in_value_i == CH_CR) || (in_value_i == CH_LF) ||
                      (in_value_i == CH_NUL);
  // Stream bytes wait while match flags are stale; load beats keep flowing.
  assign in_stall_o = busy_q || out_block || (dirty_q && (in_req_type_i == REQ_STREAM));
  assign in_acc     = in_valid_i && !in_stall_o;
  assign stream_acc = in_acc && (in_req_type_i == REQ_STREAM);
  // The rebuild starts whenever no load beat is offered, so a burst of pattern
  // writes costs a single pass.
  assign start      = dirty_q && !busy_q && !(in_valid_i && (in_req_type_i != REQ_STREAM));

  // During the rebuild, window byte 0 leaves the chain and re-enters at the end.
  // Only bytes of the current line are fed to the slot rows.
  assign feed = busy_q &&
                (((CW+1)'(rcnt_q) + (CW+1)'(count_q)) >= (CW+1)'(PAT_LEN));

  always_comb begin
    step = '0;
    if (busy_q) begin
      step.adv  = feed;
      step.data = win[0];
    end else if (start) begin
      step.clr  = 1'b1;
    end else if (stream_acc) begin
      step.clr  = is_end;
      step.adv  = !is_end;
      step.data = in_value_i;
    end
  end

  assign load.en       = in_acc && (in_req_type_i != REQ_STREAM);
  assign load.req      = in_req_type_i;
  assign load.value    = in_value_i;
  assign load.byte_pos = in_byte_pos_i;

  // Window chain: cell k takes the byte of cell k+1; the last cell takes the new byte.
  assign win_shift = busy_q || (stream_acc && !is_end);
  assign win_in    = busy_q ? win[0] : in_value_i;

  for (genvar k = 0; k < PAT_LEN; k++) begin : g_win
    logic [7:0] nxt;
    if (k == PAT_LEN - 1) begin : g_last
      assign nxt = win_in;
    end else begin : g_mid
      assign nxt = win[k+1];
    end
    lsmm_win_cell u_win (
      .clk_i   (clk_i),
      .shift_i (win_shift),
      .byte_i  (nxt),
      .byte_o  (win[k])
    );
  end

  // Slot rows: the halt set first, then the wait set.
  for (genvar s = 0; s < SLOTS; s++) begin : g_slot
    localparam int SET = s / NUM_ALTS;
    localparam int ALT = s % NUM_ALTS;
    lsmm_sel_t sel;
    assign sel.set_hit  = (in_pattern_set_i == 1'(SET));
    assign sel.slot_hit = sel.set_hit && ({1'b0, in_alt_index_i} == 3'(ALT));
    lsmm_slot #(
      .PAT_LEN (PAT_LEN)
    ) u_slot (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .step_i  (step),
      .load_i  (load),
      .sel_i   (sel),
      .hit_o   (hit[s]),
      .valid_o (valid[s])
    );
  end

  assign halt_any   = |hit[NUM_ALTS-1:0];
  assign wait_any   = |hit[SLOTS-1:NUM_ALTS];
  assign wait_empty = ~|valid[SLOTS-1:NUM_ALTS];

  // Control: rebuild sequencer and line count.
  always_comb begin
    busy_d  = busy_q;
    dirty_d = dirty_q;
    rcnt_d  = rcnt_q;
    count_d = count_q;
    if (busy_q) begin
      rcnt_d = rcnt_q + 1'b1;
      if (rcnt_q == RW'(PAT_LEN - 1)) begin
        busy_d = 1'b0;
      end
    end else if (start) begin
      busy_d  = 1'b1;
      dirty_d = 1'b0;
      rcnt_d  = '0;
    end
    if (load.en && (in_req_type_i == REQ_PAT)) begin
      dirty_d = 1'b1;
    end
    if (stream_acc) begin
      if (is_end) begin
        count_d = '0;
      end else if (count_q < CW'(PAT_LEN)) begin
        count_d = count_q + 1'b1;
      end
    end
  end

  // Output register: load beats give an all-zero result.
  always_comb begin
    out_valid_d = out_valid_q;
    halt_d      = halt_q;
    wait_d      = wait_q;
    ended_d     = ended_q;
    if (in_acc) begin
      out_valid_d = 1'b1;
      halt_d      = stream_acc && in_check_halt_i && halt_any;
      wait_d      = stream_acc && in_check_wait_i &&
                    !(in_check_halt_i && halt_any) && (wait_any || wait_empty);
      ended_d     = stream_acc && is_end;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      dirty_q     <= 1'b0;
      rcnt_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      dirty_q     <= dirty_d;
      rcnt_q      <= rcnt_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    halt_q  <= halt_d;
    wait_q  <= wait_d;
    ended_q <= ended_d;
  end

  assign out_valid_o      = out_valid_q;
  assign out_halt_hit_o   = halt_q;
  assign out_wait_hit_o   = wait_q;
  assign out_line_ended_o = ended_q;

endmodule

`default_nettype wire

@@ sv/lsmm_win_cell.sv @@
// One byte cell of the line window shift chain.
// Depends on nothing; chained by the top level.
`default_nettype none

module lsmm_win_cell (
  input  wire logic       clk_i,
  input  wire logic       shift_i,
  input  wire logic [7:0] byte_i,
  output logic      [7:0] byte_o
);

  logic [7:0] byte_q;

  // The window content is only read inside the current line, so it needs no reset.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;

endmodule

`default_nettype wire

@@ sv/lsmm_match_cell.sv @@
// One match cell: holds pattern byte i of a slot and the flag that a prefix
// of length i+1 ends at the newest byte. Depends on lsmm_pkg.
`default_nettype none

module lsmm_match_cell import lsmm_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire lsmm_step_t step_i,
  input  wire logic       pat_we_i,
  input  wire logic [7:0] pat_i,
  input  wire logic       prev_i,
  output logic            match_o,
  output logic            match_next_o
);

  logic [7:0] pat_q;
  logic       match_q;
  logic       match_d;

  always_comb begin
    match_d = match_q;
    if (step_i.clr) begin
      match_d = 1'b0;
    end else if (step_i.adv) begin
      match_d = prev_i & (pat_q == step_i.data);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pat_we_i) begin
      pat_q <= pat_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  assign match_o      = match_q;
  assign match_next_o = match_d;

endmodule

`default_nettype wire

@@ sv/lsmm_slot.sv @@
// One alternative slot: a row of match cells plus the slot's length and valid
// flag. Depends on lsmm_pkg and lsmm_match_cell.
`default_nettype none

module lsmm_slot import lsmm_pkg::*; #(
  parameter int PAT_LEN = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire lsmm_step_t step_i,
  input  wire lsmm_load_t load_i,
  input  wire lsmm_sel_t  sel_i,
  output logic            hit_o,
  output logic            valid_o
);

  localparam int LW = $clog2(PAT_LEN + 1);
  localparam int PW = ($clog2(PAT_LEN) > 5) ? $clog2(PAT_LEN) : 5;

  logic [PAT_LEN-1:0] match_q;
  logic [PAT_LEN-1:0] match_d;
  logic [PAT_LEN:0]   prefix_ok;
  logic [LW-1:0]      len_q;
  logic [LW-1:0]      len_d;
  logic               valid_q;
  logic               valid_d;
  logic               len_we;
  logic               set_clr;

  for (genvar i = 0; i < PAT_LEN; i++) begin : g_cell
    logic prev;
    logic we;
    if (i == 0) begin : g_first
      assign prev = 1'b1;
    end else begin : g_next
      assign prev = match_q[i-1];
    end
    assign we = load_i.en && sel_i.slot_hit && (load_i.req == REQ_PAT) &&
                (PW'(load_i.byte_pos) == PW'(i));
    lsmm_match_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .step_i       (step_i),
      .pat_we_i     (we),
      .pat_i        (load_i.value),
      .prev_i       (prev),
      .match_o      (match_q[i]),
      .match_next_o (match_d[i])
    );
  end

  assign len_we  = load_i.en && sel_i.slot_hit && (load_i.req == REQ_LEN);
  assign set_clr = load_i.en && sel_i.set_hit && (load_i.req == REQ_CLEAR);

  always_comb begin
    len_d   = len_q;
    valid_d = valid_q;
    if (len_we) begin
      len_d   = (load_i.value > 8'(PAT_LEN)) ? LW'(PAT_LEN) : load_i.value[LW-1:0];
      valid_d = 1'b1;
    end else if (set_clr) begin
      len_d   = '0;
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      len_q   <= len_d;
      valid_q <= valid_d;
    end
  end

  // Bit j says a prefix of length j ends at the newest byte; the empty prefix always does.
  assign prefix_ok = {match_d, 1'b1};
  assign hit_o     = valid_q && prefix_ok[len_q];
  assign valid_o   = valid_q;

endmodule

`default_nettype wire

@@ sv/lsmm_checker.sv @@
// Port-level checker of the line-suffix multi-pattern matcher and its bind.
// Depends on lsmm_pkg and line_suffix_multi_pattern_matcher_unit.
`default_nettype none

module lsmm_checker import lsmm_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic [1:0] in_req_type_i,
  input wire logic       in_check_halt_i,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic       out_halt_hit_o,
  input wire logic       out_wait_hit_o,
  input wire logic       out_line_ended_o
);

  // A stalled result beat stays and holds its fields.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_halt_hit_o) &&
    $stable(out_wait_hit_o) && $stable(out_line_ended_o))
    else $error("stalled result beat changed");

  // Every accepted beat yields a result beat in the next cycle.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("result beat missing one cycle after accept");

  // Load beats give an all-zero result.
  a_load_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_req_type_i != REQ_STREAM) |=>
    !out_halt_hit_o && !out_wait_hit_o && !out_line_ended_o)
    else $error("load beat produced a nonzero result");

  // No halt hit without a halt check.
  a_halt_gate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !in_check_halt_i |=> !out_halt_hit_o)
    else $error("halt hit without halt check");

  // Halt takes precedence over wait.
  a_precedence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_halt_hit_o |-> !out_wait_hit_o)
    else $error("halt and wait hit together");

endmodule

bind line_suffix_multi_pattern_matcher_unit lsmm_checker u_lsmm_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .in_req_type_i    (in_req_type_i),
  .in_check_halt_i  (in_check_halt_i),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .out_halt_hit_o   (out_halt_hit_o),
  .out_wait_hit_o   (out_wait_hit_o),
  .out_line_ended_o (out_line_ended_o)
);

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for line_suffix_multi_pattern_matcher_unit: directed and random
// pattern loads and stream bytes, with an in-bench predictor of the halt and wait sets.
// Depends on lsmm_pkg and the matcher top level only.
`timescale 1ns / 1ps

module testbench;
  import lsmm_pkg::*;

  localparam int PAT_LEN  = 32;
  localparam int NUM_ALTS = 4;
  localparam int SLOTS    = 2 * NUM_ALTS;

  // One input beat, field for field as it goes onto the ports.
  typedef struct packed {
    logic [1:0] req;
    logic [7:0] value;
    logic       pset;
    logic [1:0] alt;
    logic [4:0] pos;
    logic       chk_halt;
    logic       chk_wait;
  } beat_t;

  // One result beat.
  typedef struct packed {
    logic halt_hit;
    logic wait_hit;
    logic line_ended;
  } flags_t;

  logic       clk_i            = 1'b0;
  logic       rst_ni           = 1'b0;
  logic       in_valid_i       = 1'b0;
  logic       in_stall_o;
  logic [1:0] in_req_type_i    = REQ_STREAM;
  logic [7:0] in_value_i       = 8'h00;
  logic       in_pattern_set_i = 1'b0;
  logic [1:0] in_alt_index_i   = 2'd0;
  logic [4:0] in_byte_pos_i    = 5'd0;
  logic       in_check_halt_i  = 1'b0;
  logic       in_check_wait_i  = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i      = 1'b0;
  logic       out_halt_hit_o;
  logic       out_wait_hit_o;
  logic       out_line_ended_o;

  line_suffix_multi_pattern_matcher_unit #(
    .PAT_LEN (PAT_LEN),
    .NUM_ALTS(NUM_ALTS)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_req_type_i   (in_req_type_i),
    .in_value_i      (in_value_i),
    .in_pattern_set_i(in_pattern_set_i),
    .in_alt_index_i  (in_alt_index_i),
    .in_byte_pos_i   (in_byte_pos_i),
    .in_check_halt_i (in_check_halt_i),
    .in_check_wait_i (in_check_wait_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_halt_hit_o  (out_halt_hit_o),
    .out_wait_hit_o  (out_wait_hit_o),
    .out_line_ended_o(out_line_ended_o)
  );

  // Beats waiting to be driven, and the result flags still owed by the block.
  beat_t  beats_to_send[$];
  flags_t flags_awaited[$];

  // Idle and stall rates in percent, changed only between phases.
  int sender_idle_pct   = 0;
  int receiver_stall_pct = 0;
  int mismatch_count    = 0;
  int planned_beats     = 0;

  // ---------------------------------------------------------------------------
  // Predictor state: the line window, the loaded alternatives and their flags.
  // The window keeps its newest byte in the last position; line_fill counts the
  // bytes of the current line and caps at PAT_LEN, so a match never reaches
  // back into bytes from an earlier line even though they are still stored.
  // ---------------------------------------------------------------------------
  logic [7:0] line_win[PAT_LEN];
  int         line_fill = 0;
  logic [7:0] alt_bytes[SLOTS][PAT_LEN];
  int         alt_len[SLOTS];
  bit         alt_on[SLOTS];

  // Generator shadow: what the stimulus has loaded so far. It keeps track of
  // written pattern bytes so that no valid alternative ever compares a byte
  // that was never written.
  logic [7:0] plan_bytes[SLOTS][PAT_LEN];
  bit         plan_written[SLOTS][PAT_LEN];
  int         plan_len[SLOTS];
  bit         plan_on[SLOTS];

  initial begin
    for (int s = 0; s < SLOTS; s++) begin
      alt_len[s]  = 0;
      alt_on[s]   = 1'b0;
      plan_len[s] = 0;
      plan_on[s]  = 1'b0;
      for (int p = 0; p < PAT_LEN; p++) begin
        alt_bytes[s][p]    = 8'h00;
        plan_bytes[s][p]   = 8'h00;
        plan_written[s][p] = 1'b0;
      end
    end
    for (int p = 0; p < PAT_LEN; p++) line_win[p] = 8'h00;
  end

  // True when the window ends with the alternative in this slot. An alternative
  // longer than the current line never matches; a zero-length one always does.
  function automatic bit window_ends_with(int slot);
    int n;
    int i;
    n = alt_len[slot];
    if (n > line_fill) return 1'b0;
    for (i = 0; i < n; i++) begin
      if (alt_bytes[slot][i] != line_win[PAT_LEN - n + i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // A set hits when any valid alternative matches; with no valid alternative
  // the outcome is empty_hits (never for the halt set, always for the wait set).
  function automatic bit set_hits(int pset, bit empty_hits);
    int  a;
    bit  any_on;
    any_on = 1'b0;
    for (a = 0; a < NUM_ALTS; a++) begin
      if (alt_on[pset * NUM_ALTS + a]) begin
        any_on = 1'b1;
        if (window_ends_with(pset * NUM_ALTS + a)) return 1'b1;
      end
    end
    return any_on ? 1'b0 : empty_hits;
  endfunction

  // Applies one accepted beat to the predictor state and returns its result.
  function automatic flags_t scan_request(beat_t b);
    flags_t f;
    int     slot;
    int     i;
    f    = '0;
    slot = b.pset * NUM_ALTS + b.alt;
    case (b.req)
      REQ_STREAM: begin
        // A line end empties the window before the sets are evaluated.
        if (b.value == CH_LF || b.value == CH_CR || b.value == CH_NUL) begin
          line_fill    = 0;
          f.line_ended = 1'b1;
        end else begin
          for (i = 0; i < PAT_LEN - 1; i++) line_win[i] = line_win[i + 1];
          line_win[PAT_LEN - 1] = b.value;
          if (line_fill < PAT_LEN) line_fill++;
        end
        if (b.chk_halt) f.halt_hit = set_hits(0, 1'b0);
        // The halt set takes precedence over the wait set.
        if (b.chk_wait && !f.halt_hit) f.wait_hit = set_hits(1, 1'b1);
      end
      REQ_PAT: begin
        if (b.alt < NUM_ALTS && b.pos < PAT_LEN) alt_bytes[slot][b.pos] = b.value;
      end
      REQ_LEN: begin
        if (b.alt < NUM_ALTS) begin
          alt_len[slot] = (b.value > PAT_LEN) ? PAT_LEN : int'(b.value);
          alt_on[slot]  = 1'b1;
        end
      end
      default: begin
        // Clearing a set drops its slots but keeps the pattern bytes.
        for (i = 0; i < NUM_ALTS; i++) begin
          alt_on[b.pset * NUM_ALTS + i]  = 1'b0;
          alt_len[b.pset * NUM_ALTS + i] = 0;
        end
      end
    endcase
    return f;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building. Every beat goes through push_beat, which also keeps the
  // generator shadow in step with what has been queued.
  // ---------------------------------------------------------------------------
  task automatic push_beat(beat_t b);
    int slot;
    int i;
    slot = b.pset * NUM_ALTS + b.alt;
    case (b.req)
      REQ_PAT: begin
        plan_bytes[slot][b.pos]   = b.value;
        plan_written[slot][b.pos] = 1'b1;
      end
      REQ_LEN: begin
        plan_len[slot] = (b.value > PAT_LEN) ? PAT_LEN : int'(b.value);
        plan_on[slot]  = 1'b1;
      end
      REQ_CLEAR: begin
        for (i = 0; i < NUM_ALTS; i++) begin
          plan_on[b.pset * NUM_ALTS + i]  = 1'b0;
          plan_len[b.pset * NUM_ALTS + i] = 0;
        end
      end
      default: ;
    endcase
    beats_to_send.push_back(b);
    planned_beats++;
  endtask

  // Stream byte; the load-only fields carry random junk that must be ignored.
  task automatic push_byte(logic [7:0] v, bit chk_halt, bit chk_wait);
    beat_t b;
    b.req      = REQ_STREAM;
    b.value    = v;
    b.pset     = 1'($urandom_range(1));
    b.alt      = 2'($urandom_range(3));
    b.pos      = 5'($urandom_range(31));
    b.chk_halt = chk_halt;
    b.chk_wait = chk_wait;
    push_beat(b);
  endtask

  // Load beat; its check bits are random since they must not matter.
  task automatic push_load(logic [1:0] req, logic [7:0] v, bit pset, logic [1:0] alt,
                           logic [4:0] pos);
    beat_t b;
    b.req      = req;
    b.value    = v;
    b.pset     = pset;
    b.alt      = alt;
    b.pos      = pos;
    b.chk_halt = 1'($urandom_range(1));
    b.chk_wait = 1'($urandom_range(1));
    push_beat(b);
  endtask

  // Mostly a small alphabet so that random text keeps matching, sometimes any
  // byte that does not end a line.
  function automatic logic [7:0] text_byte();
    logic [7:0] v;
    if ($urandom_range(9) != 0) return 8'h61 + 8'($urandom_range(2));
    do v = 8'($urandom_range(255));
    while (v == CH_NUL || v == CH_LF || v == CH_CR);
    return v;
  endfunction

  // Makes an alternative valid, writing any of its bytes that are still unset.
  task automatic set_length(bit pset, logic [1:0] alt, logic [7:0] v);
    int slot;
    int n;
    int p;
    slot = pset * NUM_ALTS + alt;
    n    = (v > PAT_LEN) ? PAT_LEN : int'(v);
    for (p = 0; p < n; p++) begin
      if (!plan_written[slot][p]) push_load(REQ_PAT, text_byte(), pset, alt, 5'(p));
    end
    push_load(REQ_LEN, v, pset, alt, 5'($urandom_range(31)));
  endtask

  // Replays the bytes of a valid alternative into the stream.
  task automatic inject_alternative(int slot);
    int p;
    for (p = 0; p < plan_len[slot]; p++) push_byte(plan_bytes[slot][p], 1'b1, 1'b1);
  endtask

  // One well-formed sequence: optionally clear a set, load a few alternatives,
  // then stream text that now and then contains one of them. A long sequence
  // loads a full-length alternative and runs one line past the window size.
  task automatic run_episode(bit long_line);
    int   n_alts;
    int   len;
    int   r;
    int   slot;
    int   last_slot;
    bit   pset;
    logic [1:0] alt;
    int   p;
    if ($urandom_range(3) == 0) push_load(REQ_CLEAR, 8'($urandom_range(255)),
                                          1'($urandom_range(1)), 2'($urandom_range(3)),
                                          5'($urandom_range(31)));
    n_alts    = $urandom_range(1, 3);
    last_slot = 0;
    repeat (n_alts) begin
      pset = 1'($urandom_range(1));
      alt  = 2'($urandom_range(3));
      r    = $urandom_range(9);
      if (long_line)   len = $urandom_range(1) ? PAT_LEN : $urandom_range(PAT_LEN + 1, 255);
      else if (r == 0) len = 0;
      else if (r <= 7) len = $urandom_range(1, 4);
      else if (r == 8) len = $urandom_range(5, PAT_LEN - 1);
      else             len = $urandom_range(PAT_LEN, 255);
      for (p = 0; p < len && p < PAT_LEN; p++) push_load(REQ_PAT, text_byte(), pset, alt,
                                                          5'(p));
      set_length(pset, alt, 8'(len));
      last_slot = pset * NUM_ALTS + alt;
    end
    repeat (long_line ? 40 : $urandom_range(15, 35)) begin
      r = $urandom_range(99);
      if (r < 8 && !long_line) begin
        case ($urandom_range(2))
          0:       push_byte(CH_CR, 1'($urandom_range(1)), 1'($urandom_range(1)));
          1:       push_byte(CH_LF, 1'b1, 1'b1);
          default: push_byte(CH_NUL, 1'b1, 1'($urandom_range(1)));
        endcase
      end else if (r < 20) begin
        slot = $urandom_range(SLOTS - 1);
        if (plan_on[slot]) inject_alternative(slot);
      end else if (r < 25 && !long_line) begin
        push_byte(8'($urandom_range(255)), 1'b1, 1'b1);
      end else if (r < 30) begin
        // Noise: a stray load beat of any kind in the middle of the text.
        case ($urandom_range(2))
          0: push_load(REQ_PAT, 8'($urandom_range(255)), 1'($urandom_range(1)),
                       2'($urandom_range(3)), 5'($urandom_range(31)));
          1: set_length(1'($urandom_range(1)), 2'($urandom_range(3)),
                        8'($urandom_range(255)));
          default: push_load(REQ_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)),
                             2'($urandom_range(3)), 5'($urandom_range(31)));
        endcase
      end else begin
        push_byte(text_byte(), 1'($urandom_range(9) != 0), 1'($urandom_range(9) != 0));
      end
    end
    if (long_line && plan_on[last_slot]) inject_alternative(last_slot);
  endtask

  task automatic fill_random(int count);
    int start;
    start = planned_beats;
    while (planned_beats - start < count) run_episode($urandom_range(6) == 0);
  endtask

  // Short directed run covering each special case once.
  task automatic fill_directed();
    push_byte("a", 1'b1, 1'b1);        // empty halt set never hits, empty wait set does
    push_byte(CH_CR, 1'b1, 1'b1);      // line end with both sets evaluated
    push_load(REQ_PAT, "o", 1'b0, 2'd0, 5'd0);
    push_load(REQ_PAT, "k", 1'b0, 2'd0, 5'd1);
    set_length(1'b0, 2'd0, 8'd2);      // halt alternative "ok"
    push_load(REQ_PAT, 8'hFF, 1'b1, 2'd0, 5'd0);
    set_length(1'b1, 2'd0, 8'd1);      // wait alternative 0xFF
    push_byte("o", 1'b1, 1'b1);        // alternative longer than the line
    push_byte("k", 1'b1, 1'b1);        // halt hit; the wait alternative does not match
    push_byte("k", 1'b0, 1'b1);        // halt not evaluated
    push_byte(CH_NUL, 1'b1, 1'b1);
    push_byte("o", 1'b1, 1'b1);
    push_byte(CH_LF, 1'b1, 1'b1);
    push_byte("k", 1'b1, 1'b1);        // "ok" spans a line end: must not hit
    push_byte(8'hFF, 1'b1, 1'b1);      // wait hit on the top byte value
    push_load(REQ_PAT, 8'h5A, 1'b0, 2'd3, 5'd31);
    set_length(1'b0, 2'd1, 8'd0);      // zero-length halt alternative
    push_byte(CH_LF, 1'b1, 1'b1);      // zero length hits on an empty window
    push_byte("z", 1'b0, 1'b0);
    push_load(REQ_CLEAR, 8'h00, 1'b0, 2'd0, 5'd0);
    push_byte("x", 1'b1, 1'b1);
    push_load(REQ_CLEAR, 8'hFF, 1'b1, 2'd3, 5'd31);
    push_byte("x", 1'b1, 1'b1);        // wait set is empty again
    push_byte(8'h80, 1'b1, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Clock, driver and receiver stall.
  // ---------------------------------------------------------------------------
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // A beat stays on the ports until it is taken. A new beat is offered only
  // when the port is free, so valid never looks at the stall of this cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (beats_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        in_valid_i       <= 1'b1;
        in_req_type_i    <= beats_to_send[0].req;
        in_value_i       <= beats_to_send[0].value;
        in_pattern_set_i <= beats_to_send[0].pset;
        in_alt_index_i   <= beats_to_send[0].alt;
        in_byte_pos_i    <= beats_to_send[0].pos;
        in_check_halt_i  <= beats_to_send[0].chk_halt;
        in_check_wait_i  <= beats_to_send[0].chk_wait;
        beats_to_send.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks the result beat taken at this edge against the oldest
  // expectation, then predicts the input beat taken at the same edge. A
  // result can only belong to an earlier beat, so this order is safe.
  // ---------------------------------------------------------------------------
  task automatic report_field(string field, logic want, logic got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s mismatch, expected %0b, got %0b", $realtime, field, want, got);
  endtask

  flags_t want_flags;
  beat_t  taken_beat;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (flags_awaited.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result beat with nothing expected (halt %0b wait %0b end %0b)",
                     $realtime, out_halt_hit_o, out_wait_hit_o, out_line_ended_o);
        end else begin
          want_flags = flags_awaited.pop_front();
          if (want_flags.halt_hit !== out_halt_hit_o)
            report_field("halt_hit", want_flags.halt_hit, out_halt_hit_o);
          if (want_flags.wait_hit !== out_wait_hit_o)
            report_field("wait_hit", want_flags.wait_hit, out_wait_hit_o);
          if (want_flags.line_ended !== out_line_ended_o)
            report_field("line_ended", want_flags.line_ended, out_line_ended_o);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        taken_beat = '{in_req_type_i, in_value_i, in_pattern_set_i, in_alt_index_i,
                       in_byte_pos_i, in_check_halt_i, in_check_wait_i};
        flags_awaited.push_back(scan_request(taken_beat));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing: reset, then four phases with different idle and stall rates.
  // Each phase starts only after the previous one has fully drained, so the
  // sender also pauses until every owed result beat has come back.
  // ---------------------------------------------------------------------------
  task automatic drain();
    while (beats_to_send.size() != 0 || in_valid_i || flags_awaited.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // No idling on either side.
    fill_directed();
    fill_random(170);
    drain();

    // Sender idle most of the time.
    sender_idle_pct    = 80;
    receiver_stall_pct = 0;
    fill_random(170);
    drain();

    // Receiver stalling most of the time.
    sender_idle_pct    = 0;
    receiver_stall_pct = 80;
    fill_random(170);
    drain();

    // Both sides idling now and then.
    sender_idle_pct    = 20;
    receiver_stall_pct = 20;
    fill_random(170);
    drain();

    // Let any late or extra result beat show up before the verdict.
    receiver_stall_pct = 0;
    repeat (PAT_LEN + 8) @(negedge clk_i);
    if (mismatch_count == 0 && flags_awaited.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // The slowest legal run, in which every stream byte after a pattern write waits a window
  // rotation and both sides idle heavily, ends well before this 5 ms timeout.
  initial begin
    #5_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule
